[rtl/modbus_read_response_receiver_macros.svh]
// assertion macros for the modbus read response receiver checker
// expects signals named clk and rst in the scope of use
`ifndef MODBUS_READ_RESPONSE_RECEIVER_MACROS_SVH
`define MODBUS_READ_RESPONSE_RECEIVER_MACROS_SVH

// consequent checked in the same cycle
`define MRR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define MRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mrr_pkg.sv]
// shared constants, types and the crc-16/modbus byte update
// used by the window, emitter and top modules of the modbus read response receiver
`timescale 1ns / 1ps

package mrr_pkg;

  localparam int MAX_REGS        = 16;
  localparam int RX_BUFFER_BYTES = 80;
  localparam int WIN_DEPTH       = 5 + 2 * MAX_REGS;
  localparam int WIN_IDX_W       = $clog2(WIN_DEPTH);
  localparam int BCNT_W          = $clog2(RX_BUFFER_BYTES + 1);
  localparam int CNT_W           = $clog2(MAX_REGS + 1);

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [2:0]  FC_HOLDING = 3'd3;
  localparam logic [2:0]  FC_INPUT   = 3'd4;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_NODE_ADDR = 2'd0,
    REG_FUNC_CODE = 2'd1,
    REG_REG_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] node_address;
    logic [2:0] function_code;
    logic [4:0] register_count;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             status;
    logic [CNT_W-1:0] count;
  } emit_load_t;

  typedef logic [MAX_REGS-1:0][15:0] reg_vals_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/mrr_window.sv]
// byte window, per-offset crc lanes and frame match detection
// depends on mrr_pkg
`timescale 1ns / 1ps

module mrr_window (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_beat,
  input  logic [1:0]         cmd,
  input  logic [7:0]         rx_byte,
  input  mrr_pkg::cfg_t      cfg,
  output mrr_pkg::emit_load_t load,
  output mrr_pkg::reg_vals_t vals,
  output logic               frame_found
);
  import mrr_pkg::*;

  logic [WIN_DEPTH-1:0][7:0]  win;
  logic [WIN_DEPTH-1:0][7:0]  win_next;
  logic [WIN_DEPTH-1:0][15:0] crc;
  logic [WIN_DEPTH-1:0][15:0] crc_next;
  logic [BCNT_W-1:0]          bytes_received;
  logic [BCNT_W-1:0]          bytes_received_next;
  logic [WIN_IDX_W-1:0]       top_idx;
  logic [31:0]                frame_len;
  logic                       is_start;
  logic                       is_byte;
  logic                       is_timeout;
  logic                       byte_take;
  logic                       rc_ok;
  logic                       fc_ok;
  logic                       match;
  logic                       timeout;

  always_comb begin
    is_start   = 1'b0;
    is_byte    = 1'b0;
    is_timeout = 1'b0;
    unique case (cmd_t'(cmd))
      CMD_START:   is_start   = 1'b1;
      CMD_BYTE:    is_byte    = 1'b1;
      CMD_TIMEOUT: is_timeout = 1'b1;
      default: ;
    endcase
  end

  // shifted window and crc lanes
  always_comb begin
    win_next[0] = rx_byte;
    crc_next[0] = crc_byte(CRC_INIT, rx_byte);
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_next[k] = win[k-1];
      crc_next[k] = crc_byte(crc[k-1], rx_byte);
    end
  end

  always_comb begin
    byte_take = in_beat && is_byte && !frame_found &&
                (bytes_received < BCNT_W'(RX_BUFFER_BYTES));
    bytes_received_next = bytes_received + BCNT_W'(1);
    rc_ok     = (cfg.register_count != 5'd0) && (32'(cfg.register_count) <= MAX_REGS);
    fc_ok     = (cfg.function_code == FC_HOLDING) || (cfg.function_code == FC_INPUT);
    frame_len = 2 * 32'(cfg.register_count) + 32'd5;
    top_idx   = WIN_IDX_W'(2 * 32'(cfg.register_count) + 32'd4);
    match = byte_take && rc_ok && fc_ok &&
            (32'(bytes_received_next) >= frame_len) &&
            (win_next[top_idx] == cfg.node_address) &&
            (win_next[top_idx - WIN_IDX_W'(1)] == {5'd0, cfg.function_code}) &&
            (8'(2 * 32'(cfg.register_count)) == win_next[top_idx - WIN_IDX_W'(2)]) &&
            (crc_next[top_idx] == 16'h0000);
    timeout = in_beat && is_timeout && !frame_found;
  end

  // register values, big-endian, first register right after the byte count
  always_comb begin
    for (int i = 0; i < MAX_REGS; i++) begin
      if (match && (32'(i) < 32'(cfg.register_count))) begin
        vals[i] = {win_next[WIN_IDX_W'(2 * 32'(cfg.register_count) + 32'd1 - 32'(2 * i))],
                   win_next[WIN_IDX_W'(2 * 32'(cfg.register_count) - 32'(2 * i))]};
      end else begin
        vals[i] = 16'h0000;
      end
    end
  end

  always_comb begin
    load.load   = match || timeout;
    load.status = timeout;
    load.count  = match ? CNT_W'(cfg.register_count) : CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_received <= '0;
      frame_found    <= 1'b0;
    end else if (in_beat && is_start) begin
      bytes_received <= '0;
      frame_found    <= 1'b0;
    end else begin
      if (byte_take) begin
        bytes_received <= bytes_received_next;
      end
      if (match) begin
        frame_found <= 1'b1;
      end
    end
  end

  // lanes are not cleared on start and may hold older bytes; the fill count guards their use
  always_ff @(posedge clk) begin
    if (byte_take) begin
      win <= win_next;
      crc <= crc_next;
    end
  end

endmodule

[rtl/mrr_emitter.sv]
// output sequencer: holds a result run and sends one beat per cycle while out_ready is high
// depends on mrr_pkg
`timescale 1ns / 1ps

module mrr_emitter (
  input  logic                clk,
  input  logic                rst,
  input  mrr_pkg::emit_load_t load,
  input  mrr_pkg::reg_vals_t  vals,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                status,
  output logic [3:0]          reg_index,
  output logic [15:0]         reg_value,
  output logic                last,
  output logic                free
);
  import mrr_pkg::*;

  logic             busy;
  logic             status_q;
  logic [CNT_W-1:0] remaining;
  logic [3:0]       idx;
  reg_vals_t        vbuf;
  logic             take;

  always_comb begin
    last      = (remaining == CNT_W'(1));
    take      = busy && out_ready;
    free      = !busy || (out_ready && last);
    out_valid = busy;
    status    = status_q;
    reg_index = idx;
    reg_value = vbuf[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (free) begin
      busy <= load.load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load.load) begin
      status_q  <= load.status;
      remaining <= load.count;
      idx       <= 4'd0;
      vbuf      <= vals;
    end else if (take) begin
      remaining <= remaining - CNT_W'(1);
      idx       <= idx + 4'd1;
      for (int i = 0; i < MAX_REGS - 1; i++) begin
        vbuf[i] <= vbuf[i+1];
      end
      vbuf[MAX_REGS-1] <= 16'h0000;
    end
  end

endmodule

[rtl/modbus_read_response_receiver.sv]
// Modbus RTU read-registers reply receiver. Takes one command beat per cycle
// while s_axis_tready is high (start, received byte, timeout); each byte shifts a
// 37-byte window and updates the crc of every start offset in the same cycle, and
// a matching frame is seen on the byte that completes it. A match loads
// register_count result beats into the output sequencer, a timeout with no match
// loads one failure beat; results leave at one beat per cycle while m_axis_tready
// is high. While the sequencer holds results, input beats keep flowing once a
// frame has been found; otherwise the input waits until the final result beat is
// taken. Configuration writes are taken in any cycle.
// depends on mrr_pkg, mrr_window, mrr_emitter
`timescale 1ns / 1ps

module modbus_read_response_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // reg_index, reg_value, zero pad
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // status
);
  import mrr_pkg::*;

  cfg_t       cfg;
  emit_load_t load;
  reg_vals_t  vals;
  logic       frame_found;
  logic       emit_free;
  logic       in_beat;
  logic       status;
  logic [3:0] reg_index;
  logic [15:0] reg_value;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = emit_free || frame_found;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address   <= 8'd2;
      cfg.function_code  <= FC_HOLDING;
      cfg.register_count <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NODE_ADDR: cfg.node_address   <= cfg_data;
        REG_FUNC_CODE: cfg.function_code  <= cfg_data[2:0];
        REG_REG_COUNT: cfg.register_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  mrr_window u_window (
    .clk         (clk),
    .rst         (rst),
    .in_beat     (in_beat),
    .cmd         (s_axis_tuser),
    .rx_byte     (s_axis_tdata),
    .cfg         (cfg),
    .load        (load),
    .vals        (vals),
    .frame_found (frame_found)
  );

  mrr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .vals      (vals),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .status    (status),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .last      (m_axis_tlast),
    .free      (emit_free)
  );

  assign m_axis_tdata = {4'd0, reg_value, reg_index};
  assign m_axis_tuser = status;

endmodule

[rtl/mrr_checker.sv]
// port-level checks for the modbus read response receiver, bound to the top
// depends on modbus_read_response_receiver_macros.svh
`timescale 1ns / 1ps
`include "modbus_read_response_receiver_macros.svh"

module mrr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [0:0]  m_axis_tuser
);

  // stalled result beat holds
  `MRR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser),
    "result beat changed while stalled")

  // failure beat is a lone, zeroed, last beat
  `MRR_ASSERT_SAME(a_fail_beat, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tlast && (m_axis_tdata == 24'd0), "malformed failure beat")

  // a register run continues with the next index
  `MRR_ASSERT_NEXT(a_run_next, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid && !m_axis_tuser[0] &&
    (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1), "register run broken")

  // nothing leaves right after reset
  `MRR_ASSERT_SAME(a_reset_idle, $past(rst), !m_axis_tvalid, "result beat after reset")

endmodule

bind modbus_read_response_receiver mrr_checker u_mrr_checker (.*);

[tb/modbus_read_response_receiver_test.sv]
// self-checking testbench for modbus_read_response_receiver: a directed table,
// then random reply frames over several register settings and handshake mixes
// depends on mrr_pkg and the modbus_read_response_receiver rtl
`timescale 1ns / 1ps

module modbus_read_response_receiver_test;
  import mrr_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIRECTED_ROWS = 25;

  typedef enum logic [2:0] {
    SRC_LIT, SRC_BEGIN, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_BAD
  } byte_src_e;

  typedef enum logic [1:0] {
    CHK_MODEL, CHK_NONE, CHK_FAIL
  } check_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    byte_src_e  src;
    check_e     chk;
  } stim_row_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  index;
    logic [15:0] value;
    logic        last;
  } reg_reply_t;

  localparam reg_reply_t TIMEOUT_REPLY = '{1'b1, 4'd0, 16'h0000, 1'b1};

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_TIMEOUT, 8'h00, SRC_LIT,     CHK_FAIL},   // timeout straight out of reset
    '{CMD_START,   8'h00, SRC_LIT,     CHK_NONE},
    '{CMD_BYTE,    8'h02, SRC_BEGIN,   CHK_MODEL},
    '{CMD_BYTE,    8'h03, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'h02, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'hFF, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'h00, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'h00, SRC_CRC_LO,  CHK_MODEL},
    '{CMD_BYTE,    8'h00, SRC_CRC_HI,  CHK_MODEL},
    '{CMD_BYTE,    8'h55, SRC_LIT,     CHK_MODEL},  // ignored after success
    '{CMD_TIMEOUT, 8'hFF, SRC_LIT,     CHK_NONE},
    '{CMD_UNKNOWN, 8'hA5, SRC_LIT,     CHK_NONE},
    '{CMD_START,   8'hFF, SRC_LIT,     CHK_NONE},
    '{CMD_BYTE,    8'h00, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'h02, SRC_BEGIN,   CHK_MODEL},
    '{CMD_BYTE,    8'h03, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'h02, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'h12, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'h34, SRC_LIT,     CHK_MODEL},
    '{CMD_BYTE,    8'h00, SRC_CRC_LO,  CHK_MODEL},
    '{CMD_BYTE,    8'h00, SRC_CRC_BAD, CHK_MODEL},  // bad crc, skipped
    '{CMD_TIMEOUT, 8'h00, SRC_LIT,     CHK_FAIL},
    '{CMD_TIMEOUT, 8'h00, SRC_LIT,     CHK_FAIL},
    '{CMD_BYTE,    8'h80, SRC_LIT,     CHK_MODEL},
    '{CMD_START,   8'h00, SRC_LIT,     CHK_NONE}
  };

  localparam logic [7:0] PHASE_NODE  [8] = '{8'h02, 8'hFF, 8'h00, 8'h5A,
                                             8'h11, 8'h22, 8'hA5, 8'h01};
  localparam logic [7:0] PHASE_FUNC  [8] = '{8'h03, 8'h04, 8'h03, 8'h05,
                                             8'h04, 8'h03, 8'hFB, 8'h0C};
  localparam logic [7:0] PHASE_COUNT [8] = '{8'h01, 8'h10, 8'h02, 8'h03,
                                             8'h00, 8'h1F, 8'hE4, 8'h25};

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  // testbench model of the receiver's frame search state
  logic [7:0]  rx_window [WIN_DEPTH];
  logic [15:0] tail_crcs [WIN_DEPTH];
  int unsigned rx_count;
  logic        frame_done;
  logic [7:0]  cfg_node;
  logic [2:0]  cfg_func;
  logic [4:0]  cfg_regs;

  reg_reply_t expected_regs [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_taken = 0;
  int hold_left = 0;

  modbus_read_response_receiver uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic clear_run();
    for (int k = 0; k < WIN_DEPTH; k++) begin
      rx_window[k] = 8'h00;
      tail_crcs[k] = CRC_INIT;
    end
    rx_count = 0;
    frame_done = 1'b0;
  endtask

  // shift one byte in and report the register beats it releases, if any
  task automatic take_byte(input logic [7:0] b, inout reg_reply_t found [$]);
    int len;
    int hi;
    logic hit;
    if (frame_done || rx_count >= RX_BUFFER_BYTES) return;
    for (int k = WIN_DEPTH - 1; k > 0; k--) begin
      rx_window[k] = rx_window[k - 1];
      tail_crcs[k] = crc_next(tail_crcs[k - 1], b);
    end
    rx_window[0] = b;
    tail_crcs[0] = crc_next(CRC_INIT, b);
    rx_count++;
    if (cfg_regs == 0 || cfg_regs > MAX_REGS) return;
    if (cfg_func != FC_HOLDING && cfg_func != FC_INPUT) return;
    len = 5 + 2 * cfg_regs;
    if (rx_count < len) return;
    hit = rx_window[len - 1] == cfg_node && rx_window[len - 2] == {5'd0, cfg_func} &&
          rx_window[len - 3] == 8'(2 * cfg_regs) && tail_crcs[len - 1] == 16'h0000;
    if (!hit) return;
    frame_done = 1'b1;
    for (int i = 0; i < cfg_regs; i++) begin
      hi = len - 4 - 2 * i;
      found.push_back('{1'b0, 4'(i), {rx_window[hi], rx_window[hi - 1]}, i == cfg_regs - 1});
    end
  endtask

  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b, input check_e chk);
    reg_reply_t found [$];
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case (cmd)
      CMD_START: clear_run();
      CMD_BYTE: take_byte(b, found);
      CMD_TIMEOUT: if (!frame_done) found.push_back(TIMEOUT_REPLY);
      default: ;
    endcase
    if (chk == CHK_MODEL) begin
      foreach (found[i]) expected_regs.push_back(found[i]);
    end else if (chk == CHK_FAIL) begin
      expected_regs.push_back(TIMEOUT_REPLY);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_regs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NODE_ADDR: cfg_node = value;
      REG_FUNC_CODE: cfg_func = value[2:0];
      REG_REG_COUNT: cfg_regs = value[4:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] bcount, input int nregs, input logic bad_crc);
    logic [15:0] crc;
    logic [15:0] word;
    logic [7:0]  head [3];
    head = '{addr, func, bcount};
    crc = CRC_INIT;
    foreach (head[i]) begin
      crc = crc_next(crc, head[i]);
      send_beat(CMD_BYTE, head[i], CHK_MODEL);
    end
    for (int i = 0; i < nregs; i++) begin
      case ($urandom_range(7))
        0: word = 16'h0000;
        1: word = 16'hFFFF;
        default: word = 16'($urandom);
      endcase
      crc = crc_next(crc, word[15:8]);
      send_beat(CMD_BYTE, word[15:8], CHK_MODEL);
      crc = crc_next(crc, word[7:0]);
      send_beat(CMD_BYTE, word[7:0], CHK_MODEL);
    end
    send_beat(CMD_BYTE, crc[7:0], CHK_MODEL);
    send_beat(CMD_BYTE, crc[15:8] ^ {7'd0, bad_crc}, CHK_MODEL);
  endtask

  // one transaction: an optional start, some noise, a frame of some kind or none, then trailing events
  task automatic run_sequence();
    int nregs;
    int noise;
    int pick;
    logic [7:0] addr;
    logic [7:0] func;
    logic [7:0] bcount;
    nregs = (cfg_regs == 0 || cfg_regs > MAX_REGS) ? 1 : int'(cfg_regs);
    addr = cfg_node;
    func = {5'd0, cfg_func};
    bcount = 8'(2 * cfg_regs);
    if ($urandom_range(9) != 0) send_beat(CMD_START, 8'($urandom), CHK_MODEL);
    pick = $urandom_range(99);
    if (pick < 8) noise = RX_BUFFER_BYTES - (5 + 2 * nregs) + $urandom_range(1);
    else if (pick < 40) noise = $urandom_range(1, 4);
    else noise = 0;
    repeat (noise) send_beat(CMD_BYTE, 8'($urandom), CHK_MODEL);
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_frame(addr, func, bcount, nregs, 1'b0);
    end else if (pick < 72) begin
      send_frame(addr, func, bcount, nregs, 1'b1);
      if ($urandom_range(1)) send_frame(addr, func, bcount, nregs, 1'b0);
    end else if (pick < 80) begin
      send_frame(addr ^ 8'($urandom_range(1, 255)), func, bcount, nregs, 1'b0);
    end else if (pick < 86) begin
      send_frame(addr, func ^ 8'h07, bcount, nregs, 1'b0);
    end else if (pick < 92) begin
      send_frame(addr, func, bcount + 8'd2, nregs, 1'b0);
    end
    pick = $urandom_range(99);
    if (pick < 30) repeat ($urandom_range(1, 3)) send_beat(CMD_BYTE, 8'($urandom), CHK_MODEL);
    if (pick >= 20 && pick < 70) send_beat(CMD_TIMEOUT, 8'($urandom), CHK_MODEL);
    if (pick >= 60 && pick < 75) send_beat(CMD_TIMEOUT, 8'($urandom), CHK_MODEL);
    if (pick >= 90) send_beat(CMD_UNKNOWN, 8'($urandom), CHK_MODEL);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: check each beat taken and drive tready
  always @(posedge clk) begin : rx_side
    reg_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_regs.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual status %0d index %0d value %h",
                 $time, m_axis_tuser[0], m_axis_tdata[3:0], m_axis_tdata[19:4]);
        errors++;
      end else begin
        want = expected_regs.pop_front();
        check_field("status", want.status, m_axis_tuser[0]);
        check_field("reg_index", want.index, m_axis_tdata[3:0]);
        check_field("reg_value", want.value, m_axis_tdata[19:4]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
    if (hold_taken != hold_reqs) begin
      hold_taken <= hold_taken + 1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("modbus_read_response_receiver_test: errors");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] frame_crc;
    logic [7:0]  b;
    cfg_node = 8'd2;
    cfg_func = FC_HOLDING;
    cfg_regs = 5'd1;
    clear_run();
    frame_crc = CRC_INIT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      b = DIRECTED[r].data;
      case (DIRECTED[r].src)
        SRC_BEGIN: frame_crc = crc_next(CRC_INIT, b);
        SRC_CRC_LO: b = frame_crc[7:0];
        SRC_CRC_HI: b = frame_crc[15:8];
        SRC_CRC_BAD: b = frame_crc[15:8] ^ 8'h01;
        default: if (DIRECTED[r].cmd == CMD_BYTE) frame_crc = crc_next(frame_crc, b);
      endcase
      send_beat(DIRECTED[r].cmd, b, DIRECTED[r].chk);
    end

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      write_reg(REG_NODE_ADDR, PHASE_NODE[phase]);
      write_reg(REG_FUNC_CODE, PHASE_FUNC[phase]);
      write_reg(REG_REG_COUNT, PHASE_COUNT[phase]);
      cfg_valid <= 1'b0;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 85; end
        default: begin send_idle_pct = 8; recv_stall_pct <= 8; end
      endcase
      if (phase == 0 || phase == 1 || phase == 4) hold_reqs <= hold_reqs + 1;
      // two timeouts under the hold fill the result stage and stall the input
      if (phase == 0) repeat (2) send_beat(CMD_TIMEOUT, 8'h00, CHK_MODEL);
      run_sequence();
    end

    settle();
    if (errors == 0) begin
      $display("modbus_read_response_receiver_test: clean");
    end else begin
      $display("modbus_read_response_receiver_test: errors");
    end
    $finish;
  end

endmodule
